/* hdl/kmc_pkg.sv */
// Shared constants, types and a helper function for the k-mer histogram counter.
`timescale 1ns / 1ps

package kmc_pkg;

    localparam int SYMBOL_BITS    = 3;
    localparam int KMER_SYMBOLS   = 4;
    localparam int WRAP           = 4;

    localparam int KMER_BITS      = KMER_SYMBOLS * SYMBOL_BITS;
    localparam int KMER_ENTRIES   = 1 << KMER_BITS;
    localparam int SYMBOL_ENTRIES = 1 << SYMBOL_BITS;

    localparam int SYMBOL_W       = 3;
    localparam int KMER_INDEX_W   = 12;
    localparam int COUNT_W        = 32;
    localparam int LEN_W          = 32;
    localparam int POS_W          = LEN_W + 1;

    typedef logic [KMER_BITS-1:0]   kmer_addr_t;
    typedef logic [SYMBOL_BITS-1:0] sym_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef logic [LEN_W-1:0]       len_t;

    typedef struct packed {
        kmer_addr_t kmer_key;
        count_t     sym_total;
        logic       do_kmer;
        logic       do_sym;
        logic       finished;
        logic       len_err;
    } s1_t;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == '1) ? v : v + count_t'(1);
        return r;
    endfunction

endpackage

/* hdl/kmer_histogram_counter.sv */
// Top level of the k-mer and symbol histogram counter.
`timescale 1ns / 1ps
// The transfer edge reads the count; the output register loads when the update stage advances.
// Throughput: one symbol per cycle while in_stall is low; back-to-back k-mer repeats use
// write forwarding. The k-mer count memory has one write and one read port.
// Reset: asynchronous, active low; then a clear sweep zeroes the k-mer memory,
// one entry per cycle, with input stalled. Config writes are taken during the sweep.

module kmer_histogram_counter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kmc_pkg::LEN_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kmc_pkg::SYMBOL_W-1:0]      symbol,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kmc_pkg::KMER_INDEX_W-1:0]  kmer_index,
    output logic [kmc_pkg::COUNT_W-1:0]       kmer_total,
    output logic [kmc_pkg::COUNT_W-1:0]       symbol_total,
    output logic                              kmer_counted,
    output logic                              symbol_counted,
    output logic [kmc_pkg::COUNT_W-1:0]       peak_count,
    output logic                              finished,
    output logic                              length_error
);

    logic                clearing;
    logic                s1_go;
    logic                s1_valid;
    kmc_pkg::s1_t        s1;
    logic                rd_en;
    kmc_pkg::kmer_addr_t rd_addr;
    kmc_pkg::count_t     rd_data;
    logic                wr_en;
    kmc_pkg::kmer_addr_t wr_addr;
    kmc_pkg::count_t     wr_data;

    kmc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .symbol    (symbol),
        .clearing  (clearing),
        .s1_go     (s1_go),
        .s1_valid  (s1_valid),
        .s1        (s1),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    kmc_kmer_ram u_ram
    (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    kmc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid),
        .s1             (s1),
        .s1_go          (s1_go),
        .clearing       (clearing),
        .rd_data        (rd_data),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kmer_index     (kmer_index),
        .kmer_total     (kmer_total),
        .symbol_total   (symbol_total),
        .kmer_counted   (kmer_counted),
        .symbol_counted (symbol_counted),
        .peak_count     (peak_count),
        .finished       (finished),
        .length_error   (length_error)
    );

endmodule

/* hdl/kmc_kmer_ram.sv */
// K-mer count memory: one write port and one registered read port.
`timescale 1ns / 1ps

module kmc_kmer_ram
(
    input  logic                clk,
    input  logic                we,
    input  kmc_pkg::kmer_addr_t waddr,
    input  kmc_pkg::count_t     wdata,
    input  logic                re,
    input  kmc_pkg::kmer_addr_t raddr,
    output kmc_pkg::count_t     rdata
);

    kmc_pkg::count_t mem [kmc_pkg::KMER_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/kmc_front.sv */
// Input stage: config register, window, position, phase decode and symbol histogram.
`timescale 1ns / 1ps

module kmc_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [kmc_pkg::LEN_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [kmc_pkg::SYMBOL_W-1:0] symbol,
    input  logic                       clearing,
    input  logic                       s1_go,
    output logic                       s1_valid,
    output kmc_pkg::s1_t               s1,
    output logic                       rd_en,
    output kmc_pkg::kmer_addr_t        rd_addr
);

    kmc_pkg::len_t       text_length_reg;
    kmc_pkg::pos_t       last_pos_reg;
    logic                len_err_reg;
    kmc_pkg::kmer_addr_t window_reg;
    kmc_pkg::kmer_addr_t window_next;
    kmc_pkg::pos_t       position_reg;
    kmc_pkg::pos_t       position_next;
    kmc_pkg::count_t     sym_table_reg  [kmc_pkg::SYMBOL_ENTRIES];
    kmc_pkg::count_t     sym_table_next [kmc_pkg::SYMBOL_ENTRIES];
    logic                s1_valid_reg;
    logic                s1_valid_next;
    kmc_pkg::s1_t        s1_reg;
    kmc_pkg::s1_t        s1_next;

    kmc_pkg::sym_t       sym;
    logic                accept;
    logic                do_sym;
    logic                do_kmer;
    kmc_pkg::count_t     sym_old;
    kmc_pkg::count_t     sym_new;

    assign in_stall = clearing || (s1_valid_reg && !s1_go);
    assign accept   = in_valid && !in_stall;
    assign sym      = symbol[kmc_pkg::SYMBOL_BITS-1:0];

    always_comb
    begin
        window_next   = window_reg;
        position_next = position_reg;
        sym_table_next = sym_table_reg;
        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg && !s1_go;

        do_sym  = (position_reg < kmc_pkg::POS_W'(kmc_pkg::WRAP))
               || (position_reg < kmc_pkg::POS_W'(text_length_reg));
        do_kmer = (position_reg >= kmc_pkg::POS_W'(kmc_pkg::WRAP))
               && (position_reg <= last_pos_reg);
        sym_old = sym_table_reg[sym];
        sym_new = do_sym ? kmc_pkg::sat_inc(sym_old) : sym_old;

        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (len_err_reg)
            begin
                s1_next = '0;
                s1_next.len_err = 1'b1;
            end
            else
            begin
                window_next = kmc_pkg::KMER_BITS'({window_reg, sym});
                if (position_reg != '1)
                begin
                    position_next = position_reg + kmc_pkg::POS_W'(1);
                end
                sym_table_next[sym] = sym_new;
                s1_next.kmer_key  = window_next;
                s1_next.sym_total = sym_new;
                s1_next.do_kmer   = do_kmer;
                s1_next.do_sym    = do_sym;
                s1_next.finished  = (position_reg == last_pos_reg);
                s1_next.len_err   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_length_reg <= '0;
            last_pos_reg    <= kmc_pkg::POS_W'(kmc_pkg::WRAP - 1);
            len_err_reg     <= 1'b1;
            window_reg      <= '0;
            position_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            for (int i = 0; i < kmc_pkg::SYMBOL_ENTRIES; i++)
            begin
                sym_table_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                text_length_reg <= cfg_wdata;
                last_pos_reg    <= kmc_pkg::POS_W'(cfg_wdata)
                                 + kmc_pkg::POS_W'(kmc_pkg::WRAP - 1);
                len_err_reg     <= (cfg_wdata < kmc_pkg::LEN_W'(kmc_pkg::KMER_SYMBOLS));
            end
            window_reg    <= window_next;
            position_reg  <= position_next;
            s1_valid_reg  <= s1_valid_next;
            sym_table_reg <= sym_table_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;
    assign rd_en    = accept;
    assign rd_addr  = window_next;

endmodule

/* hdl/kmc_back.sv */
// Update stage: forwarding, k-mer count write-back, peak tracking, clear sweep, output register.
`timescale 1ns / 1ps

module kmc_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s1_valid,
    input  kmc_pkg::s1_t                   s1,
    output logic                           s1_go,
    output logic                           clearing,
    input  kmc_pkg::count_t                rd_data,
    output logic                           wr_en,
    output kmc_pkg::kmer_addr_t            wr_addr,
    output kmc_pkg::count_t                wr_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [kmc_pkg::KMER_INDEX_W-1:0] kmer_index,
    output logic [kmc_pkg::COUNT_W-1:0]    kmer_total,
    output logic [kmc_pkg::COUNT_W-1:0]    symbol_total,
    output logic                           kmer_counted,
    output logic                           symbol_counted,
    output logic [kmc_pkg::COUNT_W-1:0]    peak_count,
    output logic                           finished,
    output logic                           length_error
);

    logic                clear_reg;
    logic                clear_next;
    kmc_pkg::kmer_addr_t clr_addr_reg;
    kmc_pkg::kmer_addr_t clr_addr_next;
    logic                fwd_valid_reg;
    kmc_pkg::kmer_addr_t fwd_addr_reg;
    kmc_pkg::count_t     fwd_data_reg;
    kmc_pkg::count_t     peak_reg;
    kmc_pkg::count_t     peak_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [kmc_pkg::KMER_INDEX_W-1:0] kmer_index_reg;
    kmc_pkg::count_t     kmer_total_reg;
    kmc_pkg::count_t     symbol_total_reg;
    logic                kmer_counted_reg;
    logic                symbol_counted_reg;
    kmc_pkg::count_t     peak_count_reg;
    logic                finished_reg;
    logic                length_error_reg;

    kmc_pkg::count_t     kmer_old;
    kmc_pkg::count_t     kmer_new;
    logic                upd_we;

    assign s1_go    = s1_valid && (!out_valid_reg || !out_stall);
    assign clearing = clear_reg;

    always_comb
    begin
        kmer_old = (fwd_valid_reg && (fwd_addr_reg == s1.kmer_key)) ? fwd_data_reg : rd_data;
        kmer_new = s1.do_kmer ? kmc_pkg::sat_inc(kmer_old) : kmer_old;
        upd_we   = s1_go && s1.do_kmer;

        peak_next = peak_reg;
        if (upd_we && (kmer_new > peak_reg))
        begin
            peak_next = kmer_new;
        end

        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg)
        begin
            clr_addr_next = clr_addr_reg + kmc_pkg::KMER_BITS'(1);
            if (clr_addr_reg == '1)
            begin
                clear_next = 1'b0;
            end
        end

        out_valid_next = s1_go || (out_valid_reg && out_stall);

        wr_en   = clear_reg || upd_we;
        wr_addr = clear_reg ? clr_addr_reg : s1.kmer_key;
        wr_data = clear_reg ? '0 : kmer_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            fwd_valid_reg <= 1'b0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clr_addr_reg  <= clr_addr_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            if (upd_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_we)
        begin
            fwd_addr_reg <= s1.kmer_key;
            fwd_data_reg <= kmer_new;
        end
        if (s1_go)
        begin
            kmer_index_reg     <= s1.len_err ? '0 : kmc_pkg::KMER_INDEX_W'(s1.kmer_key);
            kmer_total_reg     <= s1.len_err ? '0 : kmer_new;
            symbol_total_reg   <= s1.sym_total;
            kmer_counted_reg   <= s1.do_kmer;
            symbol_counted_reg <= s1.do_sym;
            peak_count_reg     <= peak_next;
            finished_reg       <= s1.finished;
            length_error_reg   <= s1.len_err;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kmer_index     = kmer_index_reg;
    assign kmer_total     = kmer_total_reg;
    assign symbol_total   = symbol_total_reg;
    assign kmer_counted   = kmer_counted_reg;
    assign symbol_counted = symbol_counted_reg;
    assign peak_count     = peak_count_reg;
    assign finished       = finished_reg;
    assign length_error   = length_error_reg;

`ifndef SYNTHESIS
    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !s1_valid)
        else $error("item in update stage during clear sweep");

    a_peak_covers_write: assert property (@(posedge clk) disable iff (!rst_n)
        upd_we |=> (peak_reg >= $past(kmer_new)))
        else $error("peak below a written k-mer count");

    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kmer_counted_reg) |-> (kmer_total_reg != '0))
        else $error("counted k-mer reports zero total");

    a_error_counts_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && length_error_reg) |-> (!kmer_counted_reg && !symbol_counted_reg))
        else $error("length error item was counted");
`endif

endmodule
